FILE: rtl/core/lbc_pkg.sv
package lbc_pkg;

    localparam int LED_COUNT         = 4;
    localparam int LED_IDX_W         = 2;
    localparam int COUNT_W           = 8;
    localparam int STEP_W            = 10;
    localparam int TIME_FIELD_W      = 16;
    localparam int DEF_TIME_WIDTH    = 16;
    localparam int OP_W              = 4;
    localparam int S_TDATA_W         = 56;
    localparam int S_TUSER_W         = 4;
    localparam int M_TDATA_W         = 16;

    localparam logic [1:0] DIR_DOWN = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 4'd0,
        OP_ALL_OFF  = 4'd1,
        OP_ALL_ON   = 4'd2,
        OP_LED_OFF  = 4'd3,
        OP_LED_ON   = 4'd4,
        OP_SET_PAT  = 4'd5,
        OP_READ_PAT = 4'd6,
        OP_BLINK    = 4'd7,
        OP_CHASE    = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_BLINK = 3'b010,
        MODE_CHASE = 3'b100
    } t_mode;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [LED_IDX_W-1:0]    led_index;
        logic [LED_COUNT-1:0]    pattern;
        logic [COUNT_W-1:0]      repeat_count;
        logic [TIME_FIELD_W-1:0] on_time;
        logic [TIME_FIELD_W-1:0] off_time;
        logic [1:0]              direction;
        logic [LED_IDX_W-1:0]    start_led;
    } t_cmd;

    typedef struct packed {
        logic                 error_code;
        logic                 busy_res;
        logic [LED_COUNT-1:0] read_pattern;
        logic [LED_COUNT-1:0] led_pins;
    } t_result;

    function automatic logic [LED_COUNT-1:0] pin_write(
        input logic [LED_COUNT-1:0] pins,
        input logic [LED_IDX_W-1:0] idx,
        input logic                 level
    );
        logic [LED_COUNT-1:0] res;
        res      = pins;
        res[idx] = level;
        return res;
    endfunction

endpackage

FILE: rtl/core/led_blink_chase_controller_top.sv
// Controller for four active-low LED pins with blink and chase sequences.
// The slave channel takes one command per transaction: tuser carries the
// operation code and tdata the arguments. Each command, including a tick,
// produces exactly one result transaction on the master channel with the
// pin levels after the command, the read-back pattern, the busy flag and
// the busy-rejection flag.
// The input register holds each command while it is evaluated against the
// sequence state, and the result is then loaded into the result register.
// Throughput is one transaction per cycle as long as the master side keeps
// tready high; the sequence engine updates its state for every command that
// moves on to the result register.
// When the master side stalls, the result register holds its data and an
// empty input register still takes one more transaction before s_tready
// drops; nothing is lost or repeated.
// Reset is synchronous and active low: all pins go high (LEDs dark), no
// sequence is running, all counters clear and both registers empty.
module led_blink_chase_controller_top #(
    parameter int TIME_WIDTH = lbc_pkg::DEF_TIME_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // led_index[1:0], pattern[5:2], repeat_count[13:6], on_time[29:14],
    // off_time[45:30], direction[47:46], start_led[49:48], zero fill above.
    input  logic [lbc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation[3:0].
    input  logic [lbc_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // led_pins[3:0], read_pattern[7:4], busy_res[8], error_code[9], zero fill above.
    output logic [lbc_pkg::M_TDATA_W-1:0] o_m_tdata
);

    lbc_pkg::t_cmd    in_cmd;
    lbc_pkg::t_cmd    stage_cmd;
    lbc_pkg::t_result result;
    logic             stage_valid;
    logic             out_free;
    logic             adv;

    assign in_cmd.operation    = i_s_tuser;
    assign in_cmd.led_index    = i_s_tdata[1:0];
    assign in_cmd.pattern      = i_s_tdata[5:2];
    assign in_cmd.repeat_count = i_s_tdata[13:6];
    assign in_cmd.on_time      = i_s_tdata[29:14];
    assign in_cmd.off_time     = i_s_tdata[45:30];
    assign in_cmd.direction    = i_s_tdata[47:46];
    assign in_cmd.start_led    = i_s_tdata[49:48];

    assign adv = stage_valid && out_free;

    lbc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_cmd   (in_cmd),
        .i_adv   (adv),
        .o_valid (stage_valid),
        .o_cmd   (stage_cmd)
    );

    lbc_seq_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_cmd    (stage_cmd),
        .o_result (result)
    );

    lbc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata)
    );

endmodule

FILE: rtl/core/lbc_in_stage.sv
module lbc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lbc_pkg::t_cmd i_cmd,
    input  logic          i_adv,
    output logic          o_valid,
    output lbc_pkg::t_cmd o_cmd
);

    logic          r_valid;
    lbc_pkg::t_cmd r_cmd;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/lbc_seq_engine.sv
module lbc_seq_engine #(
    parameter int TIME_WIDTH = lbc_pkg::DEF_TIME_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  lbc_pkg::t_cmd    i_cmd,
    output lbc_pkg::t_result o_result
);

    logic [lbc_pkg::LED_COUNT-1:0] r_pins,  n_pins;
    lbc_pkg::t_mode                r_mode,  n_mode;
    logic                          r_lit,   n_lit;
    logic [TIME_WIDTH-1:0]         r_ticks, n_ticks;
    logic [lbc_pkg::STEP_W-1:0]    r_steps, n_steps;
    logic [lbc_pkg::LED_IDX_W-1:0] r_led,   n_led;
    logic                          r_up,    n_up;
    logic [TIME_WIDTH-1:0]         r_on,    n_on;
    logic [TIME_WIDTH-1:0]         r_off,   n_off;

    logic                          busy;
    logic [TIME_WIDTH-1:0]         on_t;
    logic [TIME_WIDTH-1:0]         off_t;
    logic [lbc_pkg::STEP_W-1:0]    steps_dec;
    logic [lbc_pkg::LED_IDX_W-1:0] led_step;
    logic [lbc_pkg::LED_COUNT-1:0] rd_pat;
    logic                          err;

    assign busy  = (r_mode != lbc_pkg::MODE_IDLE);
    assign on_t  = TIME_WIDTH'(i_cmd.on_time);
    assign off_t = TIME_WIDTH'(i_cmd.off_time);

    always_comb begin
        n_pins    = r_pins;
        n_mode    = r_mode;
        n_lit     = r_lit;
        n_ticks   = r_ticks;
        n_steps   = r_steps;
        n_led     = r_led;
        n_up      = r_up;
        n_on      = r_on;
        n_off     = r_off;
        rd_pat    = '0;
        err       = 1'b0;
        steps_dec = (r_steps != '0) ? r_steps - lbc_pkg::STEP_W'(1) : r_steps;
        led_step  = r_led;
        if (r_mode == lbc_pkg::MODE_CHASE) begin
            led_step = r_up ? r_led + lbc_pkg::LED_IDX_W'(1)
                            : r_led - lbc_pkg::LED_IDX_W'(1);
        end

        if (i_cmd.operation == lbc_pkg::OP_TICK) begin
            if (busy) begin
                if (r_ticks > TIME_WIDTH'(1)) begin
                    n_ticks = r_ticks - TIME_WIDTH'(1);
                end else if (r_lit) begin
                    n_pins  = lbc_pkg::pin_write(r_pins, r_led, 1'b1);
                    n_lit   = 1'b0;
                    n_ticks = r_off;
                end else begin
                    n_steps = steps_dec;
                    if (steps_dec == '0) begin
                        n_mode  = lbc_pkg::MODE_IDLE;
                        n_ticks = '0;
                    end else begin
                        n_led   = led_step;
                        n_lit   = 1'b1;
                        n_ticks = r_on;
                        n_pins  = lbc_pkg::pin_write(r_pins, led_step, 1'b0);
                    end
                end
            end
        end else if (i_cmd.operation <= lbc_pkg::OP_CHASE && busy) begin
            err = 1'b1;
        end else begin
            unique case (i_cmd.operation)
                lbc_pkg::OP_ALL_OFF: n_pins = '1;
                lbc_pkg::OP_ALL_ON:  n_pins = '0;
                lbc_pkg::OP_LED_OFF: n_pins = lbc_pkg::pin_write(r_pins, i_cmd.led_index, 1'b1);
                lbc_pkg::OP_LED_ON:  n_pins = lbc_pkg::pin_write(r_pins, i_cmd.led_index, 1'b0);
                lbc_pkg::OP_SET_PAT: n_pins = i_cmd.pattern;
                lbc_pkg::OP_READ_PAT: rd_pat = r_pins;
                lbc_pkg::OP_BLINK: begin
                    if (i_cmd.repeat_count != '0) begin
                        n_mode  = lbc_pkg::MODE_BLINK;
                        n_led   = i_cmd.led_index;
                        n_steps = {2'b00, i_cmd.repeat_count};
                        n_on    = on_t;
                        n_off   = off_t;
                        n_lit   = 1'b1;
                        n_ticks = on_t;
                        n_pins  = lbc_pkg::pin_write(r_pins, i_cmd.led_index, 1'b0);
                    end
                end
                lbc_pkg::OP_CHASE: begin
                    if (i_cmd.repeat_count != '0 &&
                        (i_cmd.direction == lbc_pkg::DIR_DOWN ||
                         i_cmd.direction == lbc_pkg::DIR_UP)) begin
                        n_up    = i_cmd.direction[0];
                        n_mode  = lbc_pkg::MODE_CHASE;
                        n_led   = i_cmd.start_led;
                        n_steps = {i_cmd.repeat_count, 2'b00};
                        n_on    = on_t;
                        n_off   = off_t;
                        n_lit   = 1'b1;
                        n_ticks = on_t;
                        n_pins  = lbc_pkg::pin_write(r_pins, i_cmd.start_led, 1'b0);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.led_pins     = n_pins;
    assign o_result.read_pattern = rd_pat;
    assign o_result.busy_res     = (n_mode != lbc_pkg::MODE_IDLE);
    assign o_result.error_code   = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins  <= '1;
            r_mode  <= lbc_pkg::MODE_IDLE;
            r_lit   <= 1'b0;
            r_ticks <= '0;
            r_steps <= '0;
            r_led   <= '0;
            r_up    <= 1'b0;
            r_on    <= '0;
            r_off   <= '0;
        end else if (i_fire) begin
            r_pins  <= n_pins;
            r_mode  <= n_mode;
            r_lit   <= n_lit;
            r_ticks <= n_ticks;
            r_steps <= n_steps;
            r_led   <= n_led;
            r_up    <= n_up;
            r_on    <= n_on;
            r_off   <= n_off;
        end
    end

endmodule

FILE: rtl/core/lbc_out_stage.sv
module lbc_out_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  lbc_pkg::t_result               i_result,
    output logic                           o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lbc_pkg::M_TDATA_W-1:0]  o_data
);

    logic             r_valid;
    lbc_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = lbc_pkg::M_TDATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/lbc_checker.sv
module lbc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [lbc_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // Both registers are empty right after reset; this checks the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its data.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // A rejected command is only possible while a sequence runs, which it leaves running.
    a_err_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |-> o_m_tdata[8] && o_m_tdata[7:4] == 4'd0)
        else $error("rejected command without busy or with read data");

    // Read-back data equals the unchanged pins and happens only while idle.
    a_read_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[7:4] != 4'd0 |->
            o_m_tdata[7:4] == o_m_tdata[3:0] && !o_m_tdata[8])
        else $error("read pattern differs from pin levels");

    // With the output free, the input side is never throttled.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output empty");

endmodule

bind led_blink_chase_controller_top lbc_checker u_lbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/tb_led_blink_chase_controller_top.sv
`timescale 1ns / 100ps

module tb_led_blink_chase_controller_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [lbc_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [lbc_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [lbc_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [lbc_pkg::S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [lbc_pkg::M_TDATA_W-1:0] o_m_tdata;

    logic [lbc_pkg::LED_COUNT-1:0]    pin_levels = '1;
    lbc_pkg::t_mode                   seq_mode   = lbc_pkg::MODE_IDLE;
    logic                             lit_phase  = 1'b0;
    logic [lbc_pkg::TIME_FIELD_W-1:0] ticks_left = '0;
    logic [lbc_pkg::TIME_FIELD_W-1:0] on_ticks   = '0;
    logic [lbc_pkg::TIME_FIELD_W-1:0] off_ticks  = '0;
    logic [lbc_pkg::STEP_W-1:0]       steps_left = '0;
    logic [lbc_pkg::LED_IDX_W-1:0]    lit_led    = '0;
    logic                             chase_up   = 1'b0;

    lbc_pkg::t_result expected_results[$];

    int gap_pct       = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int counted_items = 0;
    int cycle_count   = 0;

    led_blink_chase_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void start_sequence(input lbc_pkg::t_mode mode,
                                           input logic [lbc_pkg::LED_IDX_W-1:0] led,
                                           input logic [lbc_pkg::STEP_W-1:0] steps,
                                           input logic [lbc_pkg::TIME_FIELD_W-1:0] on_t,
                                           input logic [lbc_pkg::TIME_FIELD_W-1:0] off_t);
        seq_mode            = mode;
        lit_led             = led;
        steps_left          = steps;
        on_ticks            = on_t;
        off_ticks           = off_t;
        lit_phase           = 1'b1;
        ticks_left          = on_t;
        pin_levels[lit_led] = 1'b0;
    endfunction

    // A phase loaded with t ticks ends on its t-th tick; zero ticks still take one.
    function automatic void advance_sequence();
        if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
            return;
        end
        if (lit_phase) begin
            pin_levels[lit_led] = 1'b1;
            lit_phase           = 1'b0;
            ticks_left          = off_ticks;
            return;
        end
        if (steps_left != 0)
            steps_left = steps_left - 1'b1;
        if (steps_left == 0) begin
            seq_mode   = lbc_pkg::MODE_IDLE;
            ticks_left = '0;
            return;
        end
        if (seq_mode == lbc_pkg::MODE_CHASE)
            lit_led = chase_up ? lit_led + 1'b1 : lit_led - 1'b1;
        lit_phase           = 1'b1;
        ticks_left          = on_ticks;
        pin_levels[lit_led] = 1'b0;
    endfunction

    function automatic lbc_pkg::t_result predict_result(input lbc_pkg::t_cmd c);
        lbc_pkg::t_result r;
        logic             busy;
        busy = (seq_mode != lbc_pkg::MODE_IDLE);
        r    = '0;
        if (c.operation == lbc_pkg::OP_TICK) begin
            if (busy) begin
                advance_sequence();
                counted_items++;
            end
        end else if (c.operation <= lbc_pkg::OP_CHASE) begin
            counted_items++;
            if (busy) begin
                r.error_code = 1'b1;
            end else begin
                case (c.operation)
                    lbc_pkg::OP_ALL_OFF:  pin_levels = '1;
                    lbc_pkg::OP_ALL_ON:   pin_levels = '0;
                    lbc_pkg::OP_LED_OFF:  pin_levels[c.led_index] = 1'b1;
                    lbc_pkg::OP_LED_ON:   pin_levels[c.led_index] = 1'b0;
                    lbc_pkg::OP_SET_PAT:  pin_levels = c.pattern;
                    lbc_pkg::OP_READ_PAT: r.read_pattern = pin_levels;
                    lbc_pkg::OP_BLINK: begin
                        if (c.repeat_count != 0)
                            start_sequence(lbc_pkg::MODE_BLINK, c.led_index,
                                           lbc_pkg::STEP_W'(c.repeat_count),
                                           c.on_time, c.off_time);
                    end
                    lbc_pkg::OP_CHASE: begin
                        if (c.repeat_count != 0 && c.direction <= lbc_pkg::DIR_UP) begin
                            chase_up = c.direction[0];
                            start_sequence(lbc_pkg::MODE_CHASE, c.start_led,
                                           {c.repeat_count, 2'b00},
                                           c.on_time, c.off_time);
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.led_pins = pin_levels;
        r.busy_res = (seq_mode != lbc_pkg::MODE_IDLE);
        return r;
    endfunction

    function automatic lbc_pkg::t_cmd rand_cmd(input logic [lbc_pkg::OP_W-1:0] op);
        lbc_pkg::t_cmd c;
        c.operation    = op;
        c.led_index    = lbc_pkg::LED_IDX_W'($urandom_range(3));
        c.pattern      = lbc_pkg::LED_COUNT'($urandom_range(15));
        c.repeat_count = lbc_pkg::COUNT_W'($urandom_range(255));
        c.on_time      = lbc_pkg::TIME_FIELD_W'($urandom_range(65535));
        c.off_time     = lbc_pkg::TIME_FIELD_W'($urandom_range(65535));
        c.direction    = 2'($urandom_range(3));
        c.start_led    = lbc_pkg::LED_IDX_W'($urandom_range(3));
        return c;
    endfunction

    task automatic send_cmd(input lbc_pkg::t_cmd c);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.operation;
        i_s_tdata  <= lbc_pkg::S_TDATA_W'({c.start_led, c.direction, c.off_time,
                                           c.on_time, c.repeat_count, c.pattern,
                                           c.led_index});
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        expected_results.push_back(predict_result(c));
    endtask

    task automatic tick_until_idle();
        while (seq_mode != lbc_pkg::MODE_IDLE)
            send_cmd(rand_cmd(lbc_pkg::OP_TICK));
    endtask

    task automatic send_sequence(input logic [lbc_pkg::OP_W-1:0] op, input logic [7:0] cnt,
                                 input logic [lbc_pkg::TIME_FIELD_W-1:0] on_t,
                                 input logic [lbc_pkg::TIME_FIELD_W-1:0] off_t,
                                 input logic [1:0] dir,
                                 input logic [lbc_pkg::LED_IDX_W-1:0] led);
        lbc_pkg::t_cmd c;
        c              = rand_cmd(op);
        c.repeat_count = cnt;
        c.on_time      = on_t;
        c.off_time     = off_t;
        c.direction    = dir;
        c.led_index    = led;
        c.start_led    = led;
        send_cmd(c);
    endtask

    task automatic test_pin_commands();
        lbc_pkg::t_cmd c;
        send_cmd(rand_cmd(lbc_pkg::OP_READ_PAT));
        send_cmd(rand_cmd(lbc_pkg::OP_ALL_ON));
        send_cmd(rand_cmd(lbc_pkg::OP_READ_PAT));
        c = rand_cmd(lbc_pkg::OP_LED_OFF); c.led_index = 2'd0; send_cmd(c);
        c = rand_cmd(lbc_pkg::OP_LED_OFF); c.led_index = 2'd3; send_cmd(c);
        c = rand_cmd(lbc_pkg::OP_LED_ON);  c.led_index = 2'd3; send_cmd(c);
        send_cmd(rand_cmd(lbc_pkg::OP_ALL_OFF));
        c = rand_cmd(lbc_pkg::OP_LED_ON);  c.led_index = 2'd1; send_cmd(c);
        c = rand_cmd(lbc_pkg::OP_SET_PAT); c.pattern = 4'h0; send_cmd(c);
        c = rand_cmd(lbc_pkg::OP_SET_PAT); c.pattern = 4'hF; send_cmd(c);
        c = rand_cmd(lbc_pkg::OP_SET_PAT); c.pattern = 4'h5; send_cmd(c);
        send_cmd(rand_cmd(lbc_pkg::OP_READ_PAT));
        send_cmd(rand_cmd(OP_UNUSED_LO));
        send_cmd(rand_cmd(OP_UNUSED_HI));
        send_cmd(rand_cmd(lbc_pkg::OP_TICK));
    endtask

    task automatic test_sequence_corners();
        send_sequence(lbc_pkg::OP_BLINK, 8'd0, 16'hFFFF, 16'hFFFF, lbc_pkg::DIR_UP, 2'd2);
        send_sequence(lbc_pkg::OP_CHASE, 8'd0, 16'd1, 16'd1, lbc_pkg::DIR_UP, 2'd1);
        send_sequence(lbc_pkg::OP_CHASE, 8'd5, 16'd1, 16'd1, 2'd2, 2'd1);
        send_sequence(lbc_pkg::OP_CHASE, 8'd255, 16'hFFFF, 16'hFFFF, 2'd3, 2'd3);
        send_sequence(lbc_pkg::OP_BLINK, 8'd1, 16'd0, 16'd0, lbc_pkg::DIR_DOWN, 2'd3);
        tick_until_idle();
        send_sequence(lbc_pkg::OP_CHASE, 8'd1, 16'd1, 16'd0, lbc_pkg::DIR_DOWN, 2'd0);
        tick_until_idle();
        send_sequence(lbc_pkg::OP_CHASE, 8'd1, 16'd0, 16'd2, lbc_pkg::DIR_UP, 2'd3);
        tick_until_idle();
        send_cmd(rand_cmd(lbc_pkg::OP_ALL_ON));
        send_sequence(lbc_pkg::OP_BLINK, 8'd2, 16'd2, 16'd1, lbc_pkg::DIR_DOWN, 2'd0);
        tick_until_idle();
    endtask

    task automatic test_busy_rejection();
        lbc_pkg::t_cmd c;
        send_sequence(lbc_pkg::OP_BLINK, 8'd3, 16'd3, 16'd3, lbc_pkg::DIR_DOWN, 2'd1);
        for (int op = lbc_pkg::OP_ALL_OFF; op <= lbc_pkg::OP_CHASE; op++) begin
            c = rand_cmd(op[lbc_pkg::OP_W-1:0]);
            send_cmd(c);
            send_cmd(rand_cmd(lbc_pkg::OP_TICK));
        end
        send_sequence(lbc_pkg::OP_CHASE, 8'd255, 16'hFFFF, 16'hFFFF, lbc_pkg::DIR_UP, 2'd3);
        send_cmd(rand_cmd(OP_UNUSED_LO));
        send_cmd(rand_cmd(OP_UNUSED_HI));
        tick_until_idle();
    endtask

    task automatic test_longest_sequences();
        send_sequence(lbc_pkg::OP_BLINK, 8'd255, 16'd1, 16'd0, lbc_pkg::DIR_DOWN, 2'd1);
        tick_until_idle();
        send_sequence(lbc_pkg::OP_CHASE, 8'd64, 16'd0, 16'd1, lbc_pkg::DIR_UP, 2'd2);
        tick_until_idle();
        send_sequence(lbc_pkg::OP_BLINK, 8'd1, 16'd200, 16'd100, lbc_pkg::DIR_DOWN, 2'd2);
        tick_until_idle();
    endtask

    task automatic test_random_traffic(input int n);
        lbc_pkg::t_cmd              c;
        logic [lbc_pkg::OP_W-1:0]   op;
        int                         target;
        int                         sel;
        target = counted_items + n;
        while (counted_items < target) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                c = rand_cmd(($urandom_range(1) != 0) ? lbc_pkg::OP_BLINK : lbc_pkg::OP_CHASE);
                c.repeat_count = ($urandom_range(9) == 0)
                               ? lbc_pkg::COUNT_W'($urandom_range(1, 16))
                               : lbc_pkg::COUNT_W'($urandom_range(1, 3));
                c.on_time      = lbc_pkg::TIME_FIELD_W'($urandom_range(3));
                c.off_time     = lbc_pkg::TIME_FIELD_W'($urandom_range(3));
                c.direction    = 2'($urandom_range(lbc_pkg::DIR_DOWN, lbc_pkg::DIR_UP));
                send_cmd(c);
                while (seq_mode != lbc_pkg::MODE_IDLE) begin
                    c   = rand_cmd(lbc_pkg::OP_TICK);
                    sel = $urandom_range(99);
                    if (sel < 12)
                        c.operation = lbc_pkg::OP_W'($urandom_range(lbc_pkg::OP_ALL_OFF,
                                                                    lbc_pkg::OP_CHASE));
                    else if (sel < 15)
                        c.operation = lbc_pkg::OP_W'($urandom_range(OP_UNUSED_LO,
                                                                    OP_UNUSED_HI));
                    send_cmd(c);
                end
            end else if (sel < 85) begin
                op = lbc_pkg::OP_W'($urandom_range(lbc_pkg::OP_ALL_OFF, lbc_pkg::OP_READ_PAT));
                send_cmd(rand_cmd(op));
            end else if (sel < 93) begin
                op = ($urandom_range(1) != 0)
                   ? lbc_pkg::OP_TICK
                   : lbc_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                send_cmd(rand_cmd(op));
            end else begin
                c = rand_cmd(($urandom_range(1) != 0) ? lbc_pkg::OP_BLINK : lbc_pkg::OP_CHASE);
                if (c.operation == lbc_pkg::OP_BLINK || $urandom_range(1) != 0)
                    c.repeat_count = 8'd0;
                else
                    c.direction = 2'($urandom_range(2, 3));
                send_cmd(c);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        lbc_pkg::t_result got;
        lbc_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = lbc_pkg::t_result'(o_m_tdata[9:0]);
            if (expected_results.size() == 0) begin
                $error("result transaction with no command outstanding: %h", o_m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.led_pins !== want.led_pins) begin
                    $error("led_pins: expected %h, actual %h", want.led_pins, got.led_pins);
                    mismatches++;
                end
                if (got.read_pattern !== want.read_pattern) begin
                    $error("read_pattern: expected %h, actual %h",
                           want.read_pattern, got.read_pattern);
                    mismatches++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %b, actual %b", want.busy_res, got.busy_res);
                    mismatches++;
                end
                if (got.error_code !== want.error_code) begin
                    $error("error_code: expected %b, actual %b",
                           want.error_code, got.error_code);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pin_commands();
        test_sequence_corners();
        test_busy_rejection();
        test_longest_sequences();

        test_random_traffic(150);
        gap_pct   = 55;
        test_random_traffic(150);
        gap_pct   = 0;
        stall_pct = 55;
        test_random_traffic(150);
        gap_pct   = 10;
        stall_pct = 10;
        test_random_traffic(150);

        i_s_tvalid <= 1'b0;
        stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/lbc_pkg.sv
rtl/core/lbc_in_stage.sv
rtl/core/lbc_seq_engine.sv
rtl/core/lbc_out_stage.sv
rtl/core/led_blink_chase_controller_top.sv
rtl/core/lbc_checker.sv
tb/tb_led_blink_chase_controller_top.sv
